/* rtl/acpi_rdp_pkg.sv */
package acpi_rdp_pkg;

   // Descriptor kind codes
   localparam logic [3:0] KIND_IRQ            = 4'd0;
   localparam logic [3:0] KIND_DMA            = 4'd1;
   localparam logic [3:0] KIND_START_DEP      = 4'd2;
   localparam logic [3:0] KIND_END_DEP        = 4'd3;
   localparam logic [3:0] KIND_IO_PORT        = 4'd4;
   localparam logic [3:0] KIND_FIXED_IO       = 4'd5;
   localparam logic [3:0] KIND_FIXED_DMA      = 4'd6;
   localparam logic [3:0] KIND_SMALL_VENDOR   = 4'd7;
   localparam logic [3:0] KIND_END_TAG        = 4'd8;
   localparam logic [3:0] KIND_RSVD_SMALL     = 4'd9;
   localparam logic [3:0] KIND_MEMORY24       = 4'd10;
   localparam logic [3:0] KIND_LARGE_VENDOR   = 4'd11;
   localparam logic [3:0] KIND_MEMORY32       = 4'd12;
   localparam logic [3:0] KIND_FIXED_MEMORY32 = 4'd13;
   localparam logic [3:0] KIND_EXT_IRQ        = 4'd14;
   localparam logic [3:0] KIND_RSVD_LARGE     = 4'd15;

   // Byte roles
   localparam logic [1:0] ROLE_TAG     = 2'd0;
   localparam logic [1:0] ROLE_LENGTH  = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
   localparam logic [1:0] ROLE_IGNORED = 2'd3;

   // Status codes
   localparam logic [2:0] STATUS_BUSY    = 3'd0;
   localparam logic [2:0] STATUS_OK      = 3'd1;
   localparam logic [2:0] STATUS_EOR     = 3'd2;
   localparam logic [2:0] STATUS_EOF     = 3'd3;
   localparam logic [2:0] STATUS_INVALID = 3'd4;

   // Small tag type codes
   localparam logic [3:0] STYPE_IRQ          = 4'h4;
   localparam logic [3:0] STYPE_DMA          = 4'h5;
   localparam logic [3:0] STYPE_START_DEP    = 4'h6;
   localparam logic [3:0] STYPE_END_DEP      = 4'h7;
   localparam logic [3:0] STYPE_IO_PORT      = 4'h8;
   localparam logic [3:0] STYPE_FIXED_IO     = 4'h9;
   localparam logic [3:0] STYPE_FIXED_DMA    = 4'hA;
   localparam logic [3:0] STYPE_SMALL_VENDOR = 4'hE;
   localparam logic [3:0] STYPE_END_TAG      = 4'hF;

   // Large tag type codes
   localparam logic [6:0] LTYPE_MEMORY24       = 7'h01;
   localparam logic [6:0] LTYPE_LARGE_VENDOR   = 7'h04;
   localparam logic [6:0] LTYPE_MEMORY32       = 7'h05;
   localparam logic [6:0] LTYPE_FIXED_MEMORY32 = 7'h06;
   localparam logic [6:0] LTYPE_EXT_IRQ        = 7'h09;

   // Mask for the high byte of a fixed I/O base
   localparam logic [7:0] FIXED_IO_HI_MASK = 8'h03;

   // One annotated byte
   typedef struct packed {
      logic [7:0]  data_out;
      logic [3:0]  kind;
      logic [1:0]  role;
      logic [15:0] payload_index;
      logic [15:0] payload_length;
      logic        done_res;
      logic [2:0]  status;
      logic [7:0]  irq_info;
   } result_type;

   function automatic logic [3:0] small_kind(input logic [3:0] stype);
      logic [3:0] k;
      case (stype)
         STYPE_IRQ:          k = KIND_IRQ;
         STYPE_DMA:          k = KIND_DMA;
         STYPE_START_DEP:    k = KIND_START_DEP;
         STYPE_END_DEP:      k = KIND_END_DEP;
         STYPE_IO_PORT:      k = KIND_IO_PORT;
         STYPE_FIXED_IO:     k = KIND_FIXED_IO;
         STYPE_FIXED_DMA:    k = KIND_FIXED_DMA;
         STYPE_SMALL_VENDOR: k = KIND_SMALL_VENDOR;
         STYPE_END_TAG:      k = KIND_END_TAG;
         default:            k = KIND_RSVD_SMALL;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] large_kind(input logic [6:0] ltype);
      logic [3:0] k;
      case (ltype)
         LTYPE_MEMORY24:       k = KIND_MEMORY24;
         LTYPE_LARGE_VENDOR:   k = KIND_LARGE_VENDOR;
         LTYPE_MEMORY32:       k = KIND_MEMORY32;
         LTYPE_FIXED_MEMORY32: k = KIND_FIXED_MEMORY32;
         LTYPE_EXT_IRQ:        k = KIND_EXT_IRQ;
         default:              k = KIND_RSVD_LARGE;
      endcase
      return k;
   endfunction

   // Per-kind payload length rules
   function automatic logic length_ok(input logic [3:0] k, input logic [15:0] len);
      logic ok;
      case (k)
         KIND_IRQ:            ok = (len == 16'd2) || (len == 16'd3);
         KIND_DMA:            ok = (len == 16'd2);
         KIND_START_DEP:      ok = (len <= 16'd1);
         KIND_END_DEP:        ok = (len == 16'd0);
         KIND_IO_PORT:        ok = (len == 16'd7);
         KIND_FIXED_IO:       ok = (len == 16'd3);
         KIND_FIXED_DMA:      ok = (len == 16'd5);
         KIND_MEMORY24:       ok = (len == 16'd9);
         KIND_MEMORY32:       ok = (len == 16'd17);
         KIND_FIXED_MEMORY32: ok = (len == 16'd9);
         KIND_EXT_IRQ:        ok = (len >= 16'd6);
         default:             ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

/* rtl/acpi_rdp_parse.sv */
module acpi_rdp_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                in_byte,
   input  logic                      buffer_end,
   input  logic [7:0]                irq_default_info,
   output acpi_rdp_pkg::result_type  result
);

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_IGNORE  = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] seen_ff, seen_in;
   logic        inval_ff, inval_in;
   logic [7:0]  held_ff, held_in;

   logic [16:0] seen_next;
   logic [2:0]  fin_status;
   phase_type   fin_phase;

   // Decode one byte against the current parser state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      inval_in = inval_ff;
      held_in  = held_ff;

      result.data_out       = in_byte;
      result.kind           = acpi_rdp_pkg::KIND_IRQ;
      result.role           = acpi_rdp_pkg::ROLE_TAG;
      result.payload_index  = 16'd0;
      result.payload_length = 16'd0;
      result.done_res       = 1'b0;
      result.status         = acpi_rdp_pkg::STATUS_BUSY;
      result.irq_info       = 8'd0;

      seen_next  = {1'b0, seen_ff} + 17'd1;
      fin_status = acpi_rdp_pkg::STATUS_BUSY;
      fin_phase  = PH_TAG;

      case (phase_ff)
         PH_LEN_LO: begin
            result.role = acpi_rdp_pkg::ROLE_LENGTH;
            result.kind = kind_ff;
            len_in      = {8'd0, in_byte};
            if (buffer_end) begin
               result.done_res = 1'b1;
               result.status   = acpi_rdp_pkg::STATUS_EOF;
               phase_in        = PH_TAG;
            end else begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            result.role           = acpi_rdp_pkg::ROLE_LENGTH;
            result.kind           = kind_ff;
            len_in                = {in_byte, len_ff[7:0]};
            result.payload_length = len_in;
            seen_in               = 16'd0;
            inval_in              = !acpi_rdp_pkg::length_ok(kind_ff, len_in);
            fin_status = inval_in ? acpi_rdp_pkg::STATUS_INVALID :
                         (kind_ff == acpi_rdp_pkg::KIND_END_TAG) ?
                         acpi_rdp_pkg::STATUS_EOR : acpi_rdp_pkg::STATUS_OK;
            fin_phase  = (buffer_end || fin_status == acpi_rdp_pkg::STATUS_OK) ?
                         PH_TAG : PH_IGNORE;
            if (len_in == 16'd0) begin
               result.done_res = 1'b1;
               result.status   = fin_status;
               phase_in        = fin_phase;
            end else if (buffer_end) begin
               result.done_res = 1'b1;
               result.status   = acpi_rdp_pkg::STATUS_EOF;
               phase_in        = PH_TAG;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.role           = acpi_rdp_pkg::ROLE_PAYLOAD;
            result.kind           = kind_ff;
            result.payload_index  = seen_ff;
            result.payload_length = len_ff;
            if (kind_ff == acpi_rdp_pkg::KIND_FIXED_IO && seen_ff == 16'd1)
               result.data_out = in_byte & acpi_rdp_pkg::FIXED_IO_HI_MASK;
            if (kind_ff == acpi_rdp_pkg::KIND_IRQ && seen_ff == 16'd2)
               held_in = in_byte;
            fin_status = inval_ff ? acpi_rdp_pkg::STATUS_INVALID :
                         (kind_ff == acpi_rdp_pkg::KIND_END_TAG) ?
                         acpi_rdp_pkg::STATUS_EOR : acpi_rdp_pkg::STATUS_OK;
            fin_phase  = (buffer_end || fin_status == acpi_rdp_pkg::STATUS_OK) ?
                         PH_TAG : PH_IGNORE;
            if (seen_next >= {1'b0, len_ff}) begin
               result.done_res = 1'b1;
               result.status   = fin_status;
               phase_in        = fin_phase;
               if (kind_ff == acpi_rdp_pkg::KIND_IRQ &&
                   fin_status == acpi_rdp_pkg::STATUS_OK)
                  result.irq_info = (len_ff == 16'd3) ? held_in : irq_default_info;
            end else if (buffer_end) begin
               result.done_res = 1'b1;
               result.status   = acpi_rdp_pkg::STATUS_EOF;
               phase_in        = PH_TAG;
            end else begin
               seen_in = seen_next[15:0];
            end
         end
         PH_IGNORE: begin
            result.role = acpi_rdp_pkg::ROLE_IGNORED;
            if (buffer_end)
               phase_in = PH_TAG;
         end
         default: begin
            // Tag byte: small tags carry length, large tags are followed by two
            if (!in_byte[7]) begin
               kind_in = acpi_rdp_pkg::small_kind(in_byte[6:3]);
               len_in  = {13'd0, in_byte[2:0]};
            end else begin
               kind_in = acpi_rdp_pkg::large_kind(in_byte[6:0]);
               len_in  = 16'd0;
            end
            result.kind           = kind_in;
            result.payload_length = len_in;
            seen_in               = 16'd0;
            held_in               = 8'd0;
            inval_in              = !acpi_rdp_pkg::length_ok(kind_in, len_in);
            fin_status = inval_in ? acpi_rdp_pkg::STATUS_INVALID :
                         (kind_in == acpi_rdp_pkg::KIND_END_TAG) ?
                         acpi_rdp_pkg::STATUS_EOR : acpi_rdp_pkg::STATUS_OK;
            fin_phase  = (fin_status == acpi_rdp_pkg::STATUS_OK) ? PH_TAG : PH_IGNORE;
            if (buffer_end) begin
               result.done_res = 1'b1;
               result.status   = acpi_rdp_pkg::STATUS_EOR;
               phase_in        = PH_TAG;
            end else if (in_byte[7]) begin
               phase_in = PH_LEN_LO;
            end else if (len_in == 16'd0) begin
               result.done_res = 1'b1;
               result.status   = fin_status;
               phase_in        = fin_phase;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      endcase
   end

   // Advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         kind_ff  <= 4'd0;
         len_ff   <= 16'd0;
         seen_ff  <= 16'd0;
         inval_ff <= 1'b0;
         held_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         inval_ff <= inval_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* rtl/acpi_resource_descriptor_parser.sv */
// Channel   Direction  Payload
// req_*     in         tdata[7:0] in_byte; tlast buffer_end
// rsp_*     out        tdata data_out/payload_index/payload_length/status/irq_info;
//                      tuser kind/role; tlast done_res
// csr_*     in         irq_default_info write
//
// One item per cycle unless stalled; a result appears the cycle after its item.
// The per-byte decode sits between the parser state and the result register.
// Reset returns the parser to the tag phase and sets irq_default_info to 1.
// A stalled result holds; a new item is accepted in the same cycle the result
// is taken.
module acpi_resource_descriptor_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [7:0] data_out, [23:8] payload_index,
                                     // [39:24] payload_length, [42:40] status,
                                     // [50:43] irq_info, [55:51] zero
   output logic [5:0]  rsp_tuser,    // [3:0] kind, [5:4] role
   output logic        rsp_tlast,    // done_res
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic                     accept;
   logic [7:0]               irq_default_ff;
   logic                     rsp_valid_ff;
   acpi_rdp_pkg::result_type result_in;
   acpi_rdp_pkg::result_type result_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   acpi_rdp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step             (accept),
      .in_byte          (req_tdata),
      .buffer_end       (req_tlast),
      .irq_default_info (irq_default_ff),
      .result           (result_in)
   );

   // Hold the IRQ info default
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_default_ff <= 8'd1;
      end else if (csr_wr_en) begin
         irq_default_ff <= csr_wr_data;
      end
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Capture the annotated item
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.irq_info, result_ff.status,
                        result_ff.payload_length, result_ff.payload_index,
                        result_ff.data_out};
   assign rsp_tuser  = {result_ff.role, result_ff.kind};
   assign rsp_tlast  = result_ff.done_res;

   // A status is only reported on a finishing item
   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[42:40] == acpi_rdp_pkg::STATUS_BUSY)
      else $error("status reported without done");

   // Ignored bytes carry no annotation
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:4] == acpi_rdp_pkg::ROLE_IGNORED
      |-> !rsp_tlast && rsp_tuser[3:0] == 4'd0 && rsp_tdata[50:8] == 43'd0)
      else $error("ignored byte carries annotation");

   // Payload index only counts on payload bytes
   a_index_payload_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:4] != acpi_rdp_pkg::ROLE_PAYLOAD
      |-> rsp_tdata[23:8] == 16'd0)
      else $error("payload index outside payload");

   // IRQ info only on a successfully finished IRQ descriptor
   a_irq_info_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[50:43] != 8'd0
      |-> rsp_tlast && rsp_tdata[42:40] == acpi_rdp_pkg::STATUS_OK
          && rsp_tuser[3:0] == acpi_rdp_pkg::KIND_IRQ)
      else $error("irq info outside finished irq descriptor");

   // No result right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
